>>> rtl/rtpl_pkg.sv
package rtpl_pkg;

   localparam int TABLE_DEPTH_DEFAULT = 64;
   localparam int IFACE_COUNT         = 16;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_DIST_MANUAL    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIST_CONNECTED = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIST_RIP       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIST_OSPF      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIST_BGP       = 3'd4;

   localparam logic [7:0] DIST_MANUAL_RST    = 8'd1;
   localparam logic [7:0] DIST_CONNECTED_RST = 8'd0;
   localparam logic [7:0] DIST_RIP_RST       = 8'd120;
   localparam logic [7:0] DIST_OSPF_RST      = 8'd110;
   localparam logic [7:0] DIST_BGP_RST       = 8'd20;

   localparam logic [1:0] ACT_LOOKUP = 2'd0;
   localparam logic [1:0] ACT_ADD    = 2'd1;
   localparam logic [1:0] ACT_DELETE = 2'd2;

   localparam logic [2:0] SRC_MANUAL    = 3'd0;
   localparam logic [2:0] SRC_CONNECTED = 3'd1;
   localparam logic [2:0] SRC_RIP       = 3'd2;
   localparam logic [2:0] SRC_OSPF      = 3'd3;
   localparam logic [2:0] SRC_BGP       = 3'd4;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NO_ROUTE  = 3'd1;
   localparam logic [2:0] ST_DISTANCE  = 3'd2;
   localparam logic [2:0] ST_MALFORMED = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;
   localparam logic [2:0] ST_ABSENT    = 3'd5;

   localparam logic [3:0] MCAST_PREFIX = 4'hE;

   typedef enum logic [1:0] {
      OP_LOOKUP,
      OP_ADD,
      OP_DELETE,
      OP_BAD
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] address;
      logic [31:0] netmask;
      logic [31:0] gateway;
      logic [3:0]  iface;
      logic [15:0] metric;
      logic [2:0]  source;
   } cmd_type;

   typedef struct packed {
      logic [31:0] host;
      logic [31:0] mask;
      logic [31:0] gateway;
      logic [3:0]  iface;
      logic [15:0] metric;
      logic [2:0]  source;
      logic        mcast;
   } entry_type;

   typedef struct packed {
      logic [7:0] manual;
      logic [7:0] connected;
      logic [7:0] rip;
      logic [7:0] ospf;
      logic [7:0] bgp;
   } dist_type;

   function automatic logic [7:0] dist_of(dist_type d, logic [2:0] src);
      logic [7:0] r;
      case (src)
         SRC_MANUAL:    r = d.manual;
         SRC_CONNECTED: r = d.connected;
         SRC_RIP:       r = d.rip;
         SRC_OSPF:      r = d.ospf;
         default:       r = d.bgp;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/rtpl_if.sv
interface rtpl_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [31:0] address;
   logic [31:0] netmask;
   logic [31:0] gateway;
   logic [3:0]  interface_id;
   logic        interface_present;
   logic [15:0] metric;
   logic [2:0]  route_source;

   modport source (output valid, action, address, netmask, gateway, interface_id,
                   interface_present, metric, route_source, input ready);
   modport sink (input valid, action, address, netmask, gateway, interface_id,
                 interface_present, metric, route_source, output ready);
   modport monitor (input valid, ready, action, address, netmask, gateway, interface_id,
                    interface_present, metric, route_source);
endinterface

interface rtpl_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] out_gateway;
   logic [3:0]  out_interface;
   logic [15:0] out_metric;
   logic [31:0] out_netmask;

   modport source (output valid, status, out_gateway, out_interface, out_metric,
                   out_netmask, input ready);
   modport sink (input valid, status, out_gateway, out_interface, out_metric,
                 out_netmask, output ready);
   modport monitor (input valid, ready, status, out_gateway, out_interface, out_metric,
                    out_netmask);
endinterface

>>> rtl/rtpl_front.sv
module rtpl_front import rtpl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   rtpl_req_if.sink req_ch,
   output logic    cmd_valid,
   input  logic    cmd_pop,
   output cmd_type cmd
);

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push;
   logic       add_ok;
   cmd_type    cmd_in;

   assign req_ch.ready = (count_ff != 2'd2);
   assign push         = req_ch.valid && req_ch.ready;
   assign cmd_valid    = (count_ff != 2'd0);
   assign cmd          = q_ff[rd_ptr_ff];

   // An add needs host and mask both zero or both set, a real interface and a known source.
   always_comb begin
      add_ok = ((req_ch.address == 32'd0) == (req_ch.netmask == 32'd0)) &&
               req_ch.interface_present &&
               (32'(req_ch.interface_id) < 32'(IFACE_COUNT)) &&
               (req_ch.route_source <= SRC_BGP);
      cmd_in.address = req_ch.address;
      cmd_in.netmask = req_ch.netmask;
      cmd_in.gateway = req_ch.gateway;
      cmd_in.iface   = req_ch.interface_id;
      cmd_in.metric  = req_ch.metric;
      cmd_in.source  = req_ch.route_source;
      case (req_ch.action)
         ACT_LOOKUP: cmd_in.op = OP_LOOKUP;
         ACT_ADD:    cmd_in.op = add_ok ? OP_ADD : OP_BAD;
         ACT_DELETE: cmd_in.op = OP_DELETE;
         default:    cmd_in.op = OP_BAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (cmd_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(cmd_pop);
      end
   end

endmodule

>>> rtl/rtpl_back.sv
module rtpl_back import rtpl_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  dist_type  distances,
   input  logic      cmd_valid,
   output logic      cmd_pop,
   input  cmd_type   cmd,
   rtpl_rsp_if.source rsp_ch
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = AW + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_SHIFT,
      S_WRITE,
      S_RESULT
   } state_type;

   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   entry_type     mem_wdata;

   state_type     state_ff, state_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] pend_idx_ff, pend_idx_in;
   cmd_type       cmd_ff, cmd_in;
   logic          pass2_ff, pass2_in;
   logic          best_hit_ff, best_hit_in;
   entry_type     best_ff, best_in;
   logic          uni_hit_ff, uni_hit_in;
   logic [2:0]    uni_src_ff, uni_src_in;
   logic          mc_hit_ff, mc_hit_in;
   logic [2:0]    mc_src_ff, mc_src_in;
   logic          def_hit_ff, def_hit_in;
   logic [AW-1:0] def_idx_ff, def_idx_in;
   logic          dmc_hit_ff, dmc_hit_in;
   logic [AW-1:0] dmc_idx_ff, dmc_idx_in;
   logic [2:0]    status_ff, status_in;
   logic          add_after_ff, add_after_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_status_ff, rsp_status_in;
   logic [31:0]   rsp_gateway_ff, rsp_gateway_in;
   logic [3:0]    rsp_iface_ff, rsp_iface_in;
   logic [15:0]   rsp_metric_ff, rsp_metric_in;
   logic [31:0]   rsp_netmask_ff, rsp_netmask_in;

   entry_type     e;
   entry_type     new_entry;
   logic          lk_match;
   logic          last_hit;
   logic [2:0]    last_src;
   logic          found;

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.out_gateway   = rsp_gateway_ff;
   assign rsp_ch.out_interface = rsp_iface_ff;
   assign rsp_ch.out_metric    = rsp_metric_ff;
   assign rsp_ch.out_netmask   = rsp_netmask_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   always_comb begin
      e = rd_data_ff;
      new_entry.host    = cmd_ff.address;
      new_entry.mask    = cmd_ff.netmask;
      new_entry.gateway = cmd_ff.gateway;
      new_entry.iface   = cmd_ff.iface;
      new_entry.metric  = cmd_ff.metric;
      new_entry.source  = cmd_ff.source;
      new_entry.mcast   = (cmd_ff.address[31:28] == MCAST_PREFIX);
      lk_match = pass2_ff ? (e.host == cmd_ff.address)
                          : (((cmd_ff.address ^ e.host) & e.mask) == 32'd0);
      // The last matching route counts multicast entries after all unicast ones.
      last_hit = mc_hit_ff || uni_hit_ff;
      last_src = mc_hit_ff ? mc_src_ff : uni_src_ff;
      found    = (status_ff == ST_OK) && (cmd_ff.op == OP_LOOKUP);

      state_in       = state_ff;
      n_in           = n_ff;
      idx_in         = idx_ff;
      pend_in        = 1'b0;
      pend_idx_in    = idx_ff[AW-1:0];
      cmd_in         = cmd_ff;
      pass2_in       = pass2_ff;
      best_hit_in    = best_hit_ff;
      best_in        = best_ff;
      uni_hit_in     = uni_hit_ff;
      uni_src_in     = uni_src_ff;
      mc_hit_in      = mc_hit_ff;
      mc_src_in      = mc_src_ff;
      def_hit_in     = def_hit_ff;
      def_idx_in     = def_idx_ff;
      dmc_hit_in     = dmc_hit_ff;
      dmc_idx_in     = dmc_idx_ff;
      status_in      = status_ff;
      add_after_in   = add_after_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_gateway_in = rsp_gateway_ff;
      rsp_iface_in   = rsp_iface_ff;
      rsp_metric_in  = rsp_metric_ff;
      rsp_netmask_in = rsp_netmask_ff;
      cmd_pop        = 1'b0;
      mem_we         = 1'b0;
      mem_waddr      = n_ff[AW-1:0];
      mem_wdata      = new_entry;
      mem_raddr      = idx_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop     = 1'b1;
               cmd_in      = cmd;
               idx_in      = '0;
               pass2_in    = 1'b0;
               best_hit_in = 1'b0;
               uni_hit_in  = 1'b0;
               mc_hit_in   = 1'b0;
               def_hit_in  = 1'b0;
               dmc_hit_in  = 1'b0;
               if (cmd.op == OP_BAD) begin
                  status_in = ST_MALFORMED;
                  state_in  = S_RESULT;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (idx_ff < n_ff) begin
               pend_in = 1'b1;
               idx_in  = idx_ff + CW'(1);
            end
            if (pend_ff) begin
               case (cmd_ff.op)
                  OP_LOOKUP: begin
                     if (!e.mcast && lk_match && (!best_hit_ff || e.mask > best_ff.mask)) begin
                        best_hit_in = 1'b1;
                        best_in     = e;
                     end
                  end
                  OP_ADD: begin
                     if ((cmd_ff.address == 32'd0 || cmd_ff.address == e.host) &&
                         (cmd_ff.netmask == 32'd0 || cmd_ff.netmask == e.mask)) begin
                        if (e.mcast) begin
                           mc_hit_in = 1'b1;
                           mc_src_in = e.source;
                        end else begin
                           uni_hit_in = 1'b1;
                           uni_src_in = e.source;
                        end
                     end
                     if (!e.mcast && e.mask == 32'd0 && !def_hit_ff) begin
                        def_hit_in = 1'b1;
                        def_idx_in = pend_idx_ff;
                     end
                  end
                  OP_DELETE: begin
                     if (e.host == cmd_ff.address && e.mask == cmd_ff.netmask) begin
                        if (e.mcast) begin
                           if (!dmc_hit_ff) begin
                              dmc_hit_in = 1'b1;
                              dmc_idx_in = pend_idx_ff;
                           end
                        end else if (!def_hit_ff) begin
                           def_hit_in = 1'b1;
                           def_idx_in = pend_idx_ff;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
            if (idx_ff >= n_ff && !pend_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            case (cmd_ff.op)
               OP_LOOKUP: begin
                  if (best_hit_ff && !pass2_ff && best_ff.host != cmd_ff.address) begin
                     // Second pass keeps only entries whose host is the address itself.
                     pass2_in    = 1'b1;
                     best_hit_in = 1'b0;
                     idx_in      = '0;
                     state_in    = S_SCAN;
                  end else begin
                     status_in = best_hit_ff ? ST_OK : ST_NO_ROUTE;
                     state_in  = S_RESULT;
                  end
               end
               OP_ADD: begin
                  add_after_in = 1'b1;
                  if (last_hit &&
                      !(dist_of(distances, cmd_ff.source) < dist_of(distances, last_src)))
                  begin
                     status_in = ST_DISTANCE;
                     state_in  = S_RESULT;
                  end else if (cmd_ff.netmask == 32'd0 && def_hit_ff) begin
                     status_in = ST_OK;
                     idx_in    = {1'b0, def_idx_ff} + CW'(1);
                     state_in  = S_SHIFT;
                  end else if (n_ff == CW'(TABLE_DEPTH)) begin
                     status_in = ST_FULL;
                     state_in  = S_RESULT;
                  end else begin
                     state_in = S_WRITE;
                  end
               end
               OP_DELETE: begin
                  add_after_in = 1'b0;
                  status_in    = ST_OK;
                  if (def_hit_ff) begin
                     idx_in   = {1'b0, def_idx_ff} + CW'(1);
                     state_in = S_SHIFT;
                  end else if (dmc_hit_ff) begin
                     idx_in   = {1'b0, dmc_idx_ff} + CW'(1);
                     state_in = S_SHIFT;
                  end else begin
                     status_in = ST_ABSENT;
                     state_in  = S_RESULT;
                  end
               end
               default: begin
                  status_in = ST_MALFORMED;
                  state_in  = S_RESULT;
               end
            endcase
         end
         S_SHIFT: begin
            // Each later entry is read, then written one slot lower on the next cycle.
            if (idx_ff < n_ff) begin
               pend_in = 1'b1;
               idx_in  = idx_ff + CW'(1);
            end
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = pend_idx_ff - AW'(1);
               mem_wdata = rd_data_ff;
            end
            if (idx_ff >= n_ff && !pend_ff) begin
               n_in     = n_ff - CW'(1);
               state_in = add_after_ff ? S_WRITE : S_RESULT;
            end
         end
         S_WRITE: begin
            mem_we    = 1'b1;
            n_in      = n_ff + CW'(1);
            status_in = ST_OK;
            state_in  = S_RESULT;
         end
         S_RESULT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_gateway_in = found ? best_ff.gateway : 32'd0;
               rsp_iface_in   = found ? best_ff.iface : 4'd0;
               rsp_metric_in  = found ? best_ff.metric : 16'd0;
               rsp_netmask_in = found ? best_ff.mask : 32'd0;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         n_ff         <= '0;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_idx_ff    <= pend_idx_in;
      cmd_ff         <= cmd_in;
      pass2_ff       <= pass2_in;
      best_hit_ff    <= best_hit_in;
      best_ff        <= best_in;
      uni_hit_ff     <= uni_hit_in;
      uni_src_ff     <= uni_src_in;
      mc_hit_ff      <= mc_hit_in;
      mc_src_ff      <= mc_src_in;
      def_hit_ff     <= def_hit_in;
      def_idx_ff     <= def_idx_in;
      dmc_hit_ff     <= dmc_hit_in;
      dmc_idx_ff     <= dmc_idx_in;
      status_ff      <= status_in;
      add_after_ff   <= add_after_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_gateway_ff <= rsp_gateway_in;
      rsp_iface_ff   <= rsp_iface_in;
      rsp_metric_ff  <= rsp_metric_in;
      rsp_netmask_ff <= rsp_netmask_in;
   end

endmodule

>>> rtl/route_table_prefix_lookup_core.sv
// Channel  Direction  Handshake          Payload
// req_ch   in         valid/ready        action, address, netmask, gateway, interface_id,
//                                        interface_present, metric, route_source
// rsp_ch   out        valid/ready        status, out_gateway, out_interface, out_metric,
//                                        out_netmask
// csr      in         csr_write_en       csr_index, csr_write_data (five distances)
//
// One transaction at a time runs in the back end. It walks the packed entries through a
// table memory with one read and one write port at one entry per cycle: a lookup scans
// the n routes held (up to TABLE_DEPTH), and again on a second pass when needed; an add
// or delete scans once and may free a slot by moving later entries down. A malformed
// request goes straight to its result. The back end goes idle between transactions.
// Reset empties the table at once through the route count; no clearing pass is needed.
// A two-entry queue takes new requests while the back end works or the result stalls.
module route_table_prefix_lookup_core import rtpl_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   rtpl_req_if.sink               req_ch,
   rtpl_rsp_if.source             rsp_ch,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   dist_type dist_ff;
   logic     cmd_valid;
   logic     cmd_pop;
   cmd_type  cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff.manual    <= DIST_MANUAL_RST;
         dist_ff.connected <= DIST_CONNECTED_RST;
         dist_ff.rip       <= DIST_RIP_RST;
         dist_ff.ospf      <= DIST_OSPF_RST;
         dist_ff.bgp       <= DIST_BGP_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_DIST_MANUAL:    dist_ff.manual    <= csr_write_data;
            CSR_DIST_CONNECTED: dist_ff.connected <= csr_write_data;
            CSR_DIST_RIP:       dist_ff.rip       <= csr_write_data;
            CSR_DIST_OSPF:      dist_ff.ospf      <= csr_write_data;
            CSR_DIST_BGP:       dist_ff.bgp       <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   rtpl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd)
   );

   rtpl_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .distances (dist_ff),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd),
      .rsp_ch    (rsp_ch)
   );

endmodule

>>> rtl/rtpl_checker.sv
module rtpl_checker import rtpl_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [31:0] rsp_gateway,
   input logic [3:0]  rsp_interface,
   input logic [15:0] rsp_metric,
   input logic [31:0] rsp_netmask
);

   // Nothing is offered in the cycle after reset.
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("stalled result changed");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_ABSENT)
      else $error("status code out of range");

   // Only a successful lookup carries route fields.
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |->
         rsp_gateway == 32'd0 && rsp_interface == 4'd0 &&
         rsp_metric == 16'd0 && rsp_netmask == 32'd0)
      else $error("route fields set on a failed transaction");

endmodule

bind route_table_prefix_lookup_core rtpl_checker u_rtpl_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_status    (rsp_ch.status),
   .rsp_gateway   (rsp_ch.out_gateway),
   .rsp_interface (rsp_ch.out_interface),
   .rsp_metric    (rsp_ch.out_metric),
   .rsp_netmask   (rsp_ch.out_netmask)
);

>>> bench/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rtpl_pkg::*;

   localparam int DEPTH = TABLE_DEPTH_DEFAULT;
   localparam int IDLE_LIMIT = 20000;
   localparam logic [1:0] ACT_UNKNOWN = 2'd3;
   localparam logic [2:0] SRC_UNKNOWN = 3'd7;

   typedef struct {
      logic [1:0]  action;
      logic [31:0] address;
      logic [31:0] netmask;
      logic [31:0] gateway;
      logic [3:0]  iface;
      logic        present;
      logic [15:0] metric;
      logic [2:0]  source;
   } route_req_type;

   typedef struct {
      logic [2:0]  status;
      logic [31:0] gateway;
      logic [3:0]  iface;
      logic [15:0] metric;
      logic [31:0] netmask;
   } route_rsp_type;

   typedef struct {
      route_req_type req;
      logic          fixed;
      logic [2:0]    status;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   rtpl_req_if req_ch ();
   rtpl_rsp_if rsp_ch ();

   route_table_prefix_lookup_core dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_write_data(csr_write_data)
   );

   always #4 clock = ~clock;

   // Shadow copy of the route table and distances.
   dist_type      shadow_dist;
   entry_type     tbl [DEPTH];
   int            used;
   route_rsp_type pending_rsps [$];
   int            errors = 0;
   int            send_idle_pct = 0;
   int            recv_stall_pct = 0;
   int            quiet_cycles = 0;

   function automatic logic [7:0] distance_for(logic [2:0] src);
      case (src)
         SRC_MANUAL:    return shadow_dist.manual;
         SRC_CONNECTED: return shadow_dist.connected;
         SRC_RIP:       return shadow_dist.rip;
         SRC_OSPF:      return shadow_dist.ospf;
         default:       return shadow_dist.bgp;
      endcase
   endfunction

   function automatic void drop_entry(int k);
      for (int i = k; i + 1 < used; i++) tbl[i] = tbl[i + 1];
      if (used > 0) used--;
   endfunction

   function automatic int best_route(logic [31:0] addr);
      int best;
      best = -1;
      for (int i = 0; i < used; i++)
         if (!tbl[i].mcast && ((addr ^ tbl[i].host) & tbl[i].mask) == 0 &&
             (best < 0 || tbl[i].mask > tbl[best].mask)) best = i;
      if (best >= 0 && tbl[best].host != addr) begin
         best = -1;
         for (int i = 0; i < used; i++)
            if (!tbl[i].mcast && tbl[i].host == addr &&
                (best < 0 || tbl[i].mask > tbl[best].mask)) best = i;
      end
      return best;
   endfunction

   function automatic logic [2:0] apply_add(route_req_type r);
      int last, dflt;
      if ((r.address == 0) != (r.netmask == 0)) return ST_MALFORMED;
      if (!r.present || r.iface >= IFACE_COUNT || r.source > SRC_BGP) return ST_MALFORMED;
      last = -1;
      for (int pass = 0; pass < 2; pass++)
         for (int i = 0; i < used; i++) begin
            if (tbl[i].mcast != pass[0]) continue;
            if (r.address != 0 && r.address != tbl[i].host) continue;
            if (r.netmask != 0 && r.netmask != tbl[i].mask) continue;
            last = i;
         end
      if (last >= 0 && !(distance_for(r.source) < distance_for(tbl[last].source)))
         return ST_DISTANCE;
      dflt = -1;
      if (r.netmask == 0)
         for (int i = 0; i < used; i++)
            if (dflt < 0 && !tbl[i].mcast && tbl[i].mask == 0) dflt = i;
      if (used >= DEPTH && dflt < 0) return ST_FULL;
      if (dflt >= 0) drop_entry(dflt);
      tbl[used] = '{host: r.address, mask: r.netmask, gateway: r.gateway, iface: r.iface,
                    metric: r.metric, source: r.source,
                    mcast: (r.address[31:28] == MCAST_PREFIX)};
      used++;
      return ST_OK;
   endfunction

   function automatic route_rsp_type predict_route(route_req_type r);
      route_rsp_type p;
      int k;
      p = '{default: '0};
      case (r.action)
         ACT_LOOKUP: begin
            k = best_route(r.address);
            if (k >= 0) begin
               p.gateway = tbl[k].gateway;
               p.iface   = tbl[k].iface;
               p.metric  = tbl[k].metric;
               p.netmask = tbl[k].mask;
               p.status  = ST_OK;
            end else begin
               p.status = ST_NO_ROUTE;
            end
         end
         ACT_ADD: p.status = apply_add(r);
         ACT_DELETE: begin
            p.status = ST_ABSENT;
            for (int pass = 0; pass < 2; pass++)
               for (int i = 0; i < used; i++)
                  if (p.status == ST_ABSENT && tbl[i].mcast == pass[0] &&
                      tbl[i].host == r.address && tbl[i].mask == r.netmask) begin
                     drop_entry(i);
                     p.status = ST_OK;
                  end
         end
         default: p.status = ST_MALFORMED;
      endcase
      return p;
   endfunction

   // Response side: stall at random, check each transaction against the oldest prediction.
   always @(posedge clock) begin
      route_rsp_type e;
      if (!reset) begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsps.size() == 0) begin
               $display("%0t: unexpected response status %0d", $time, rsp_ch.status);
               errors++;
            end else begin
               e = pending_rsps.pop_front();
               if (rsp_ch.status !== e.status || rsp_ch.out_gateway !== e.gateway ||
                   rsp_ch.out_interface !== e.iface || rsp_ch.out_metric !== e.metric ||
                   rsp_ch.out_netmask !== e.netmask) begin
                  $display("%0t: expected st %0d gw %h if %0d met %0d nm %h", $time,
                           e.status, e.gateway, e.iface, e.metric, e.netmask);
                  $display("%0t: actual   st %0d gw %h if %0d met %0d nm %h", $time,
                           rsp_ch.status, rsp_ch.out_gateway, rsp_ch.out_interface,
                           rsp_ch.out_metric, rsp_ch.out_netmask);
                  errors++;
               end
            end
         end
      end
   end

   always @(negedge clock)
      rsp_ch.ready <= !reset && ($urandom_range(99) >= recv_stall_pct);

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
         end
      end
   end

   task automatic send_route(route_req_type r, logic fixed, logic [2:0] st);
      route_rsp_type p;
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.action <= r.action;
      req_ch.address <= r.address;
      req_ch.netmask <= r.netmask;
      req_ch.gateway <= r.gateway;
      req_ch.interface_id <= r.iface;
      req_ch.interface_present <= r.present;
      req_ch.metric <= r.metric;
      req_ch.route_source <= r.source;
      do @(posedge clock); while (!req_ch.ready);
      p = predict_route(r);
      if (fixed && p.status != st) begin
         $display("%0t: expected table status %0d, predicted %0d", $time, st, p.status);
         errors++;
      end
      pending_rsps.insert(pending_rsps.size(), p);
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   task automatic drain_rsps();
      while (pending_rsps.size() != 0) @(negedge clock);
      repeat (2 * DEPTH + 40) @(negedge clock);
   endtask

   task automatic write_distance(logic [CSR_INDEX_W-1:0] idx, logic [7:0] v);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= v;
      @(negedge clock);
      csr_write_en = 1'b0;
      case (idx)
         CSR_DIST_MANUAL:    shadow_dist.manual = v;
         CSR_DIST_CONNECTED: shadow_dist.connected = v;
         CSR_DIST_RIP:       shadow_dist.rip = v;
         CSR_DIST_OSPF:      shadow_dist.ospf = v;
         default:            shadow_dist.bgp = v;
      endcase
   endtask

   function automatic route_req_type mk(logic [1:0] a, logic [31:0] ad, logic [31:0] nm,
                                        logic [31:0] gw, logic [3:0] ifc, logic ip,
                                        logic [15:0] met, logic [2:0] src);
      return '{action: a, address: ad, netmask: nm, gateway: gw, iface: ifc, present: ip,
               metric: met, source: src};
   endfunction

   // Random transactions draw from a small pool of prefixes so that matches are common.
   function automatic route_req_type rand_route();
      route_req_type r;
      logic [31:0] pool_host [8] = '{32'h0A000000, 32'h0A010000, 32'h0A010203, 32'hC0A80100,
                                     32'hE0000001, 32'hFFFFFFFF, 32'h00000000, 32'h0A0100FF};
      logic [31:0] pool_mask [6] = '{32'hFF000000, 32'hFFFF0000, 32'hFFFFFF00,
                                     32'hFFFFFFFF, 32'h00000000, 32'hFFFFFFF0};
      int k;
      r.address = pool_host[$urandom_range(7)];
      r.netmask = pool_mask[$urandom_range(5)];
      if (r.address == 0 && $urandom_range(3) != 0) r.netmask = 0;
      if (r.netmask == 0 && r.address != 0 && $urandom_range(3) != 0) r.netmask = 32'hFF000000;
      k = $urandom_range(99);
      if (k < 10) begin
         r.address = $urandom();
         r.netmask = $urandom();
      end
      r.gateway = $urandom();
      r.iface = $urandom_range(15);
      r.present = ($urandom_range(15) != 0);
      r.metric = $urandom();
      r.source = ($urandom_range(15) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
      k = $urandom_range(99);
      if (k < 45) begin
         r.action = ACT_LOOKUP;
         if ($urandom_range(1)) r.address = r.address | 32'($urandom_range(255));
      end else if (k < 80) r.action = ACT_ADD;
      else if (k < 97) r.action = ACT_DELETE;
      else r.action = ACT_UNKNOWN;
      return r;
   endfunction

   stim_row_type directed [] = '{
      '{mk(ACT_LOOKUP, 32'h0A010203, 0, 0, 0, 0, 0, SRC_MANUAL), 1'b1, ST_NO_ROUTE},
      '{mk(ACT_DELETE, 32'h0A000000, 32'hFF000000, 0, 0, 0, 0, SRC_MANUAL), 1'b1, ST_ABSENT},
      '{mk(ACT_UNKNOWN, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 1, 0, SRC_MANUAL), 1'b1,
        ST_MALFORMED},
      '{mk(ACT_ADD, 32'h0A000000, 0, 1, 1, 1, 1, SRC_MANUAL), 1'b1, ST_MALFORMED},
      '{mk(ACT_ADD, 0, 32'hFF000000, 1, 1, 1, 1, SRC_MANUAL), 1'b1, ST_MALFORMED},
      '{mk(ACT_ADD, 32'h0A000000, 32'hFF000000, 1, 1, 0, 1, SRC_MANUAL), 1'b1, ST_MALFORMED},
      '{mk(ACT_ADD, 32'h0A000000, 32'hFF000000, 1, 1, 1, 1, SRC_UNKNOWN), 1'b1, ST_MALFORMED},
      '{mk(ACT_ADD, 32'h0A000000, 32'hFF000000, 32'h0A0000FE, 4'd2, 1, 16'd5, SRC_RIP),
        1'b1, ST_OK},
      '{mk(ACT_ADD, 32'h0A010000, 32'hFFFF0000, 32'hFFFFFFFF, 4'd15, 1, 16'hFFFF,
           SRC_MANUAL), 1'b1, ST_OK},
      '{mk(ACT_ADD, 32'h0A000000, 32'hFF000000, 32'h1, 4'd3, 1, 16'd9, SRC_RIP),
        1'b1, ST_DISTANCE},
      '{mk(ACT_ADD, 32'h0A000000, 32'hFF000000, 32'h2, 4'd4, 1, 16'd1, SRC_BGP),
        1'b0, ST_OK},
      '{mk(ACT_ADD, 0, 0, 32'hC0A80001, 4'd0, 1, 16'd0, SRC_CONNECTED), 1'b0, ST_OK},
      '{mk(ACT_ADD, 0, 0, 32'hC0A80002, 4'd1, 1, 16'd0, SRC_CONNECTED), 1'b0, ST_OK},
      '{mk(ACT_ADD, 32'hE0000001, 32'hFFFFFFFF, 32'h5, 4'd5, 1, 16'd2, SRC_OSPF),
        1'b0, ST_OK},
      '{mk(ACT_LOOKUP, 32'hE0000001, 0, 0, 0, 0, 0, SRC_MANUAL), 1'b0, ST_OK},
      '{mk(ACT_LOOKUP, 32'h0A010000, 0, 0, 0, 0, 0, SRC_MANUAL), 1'b0, ST_OK},
      '{mk(ACT_LOOKUP, 32'h0A010203, 0, 0, 0, 0, 0, SRC_MANUAL), 1'b0, ST_OK},
      '{mk(ACT_LOOKUP, 32'hFFFFFFFF, 0, 0, 0, 0, 0, SRC_MANUAL), 1'b0, ST_OK},
      '{mk(ACT_LOOKUP, 32'h00000000, 0, 0, 0, 0, 0, SRC_MANUAL), 1'b0, ST_OK},
      '{mk(ACT_DELETE, 32'h0A010000, 32'hFFFF0000, 0, 0, 0, 0, SRC_MANUAL), 1'b0, ST_OK},
      '{mk(ACT_DELETE, 0, 0, 0, 0, 0, 0, SRC_MANUAL), 1'b0, ST_OK},
      '{mk(ACT_LOOKUP, 32'h0A010203, 0, 0, 0, 0, 0, SRC_MANUAL), 1'b0, ST_OK}
   };

   initial begin
      route_req_type r;
      req_ch.valid = 1'b0;
      req_ch.action = '0;
      req_ch.address = '0;
      req_ch.netmask = '0;
      req_ch.gateway = '0;
      req_ch.interface_id = '0;
      req_ch.interface_present = 1'b0;
      req_ch.metric = '0;
      req_ch.route_source = '0;
      shadow_dist = '{manual: DIST_MANUAL_RST, connected: DIST_CONNECTED_RST,
                      rip: DIST_RIP_RST, ospf: DIST_OSPF_RST, bgp: DIST_BGP_RST};
      used = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed[i]) send_route(directed[i].req, directed[i].fixed, directed[i].status);
      drain_rsps();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
            default: begin send_idle_pct = 34; recv_stall_pct = 34; end
         endcase
         case (ph)
            1: for (int k = 0; k < 5; k++) write_distance(k[CSR_INDEX_W-1:0], 8'd255);
            2: for (int k = 0; k < 5; k++) write_distance(k[CSR_INDEX_W-1:0], 8'd0);
            3: for (int k = 0; k < 5; k++) write_distance(k[CSR_INDEX_W-1:0], 8'($urandom()));
            5: begin
               write_distance(CSR_DIST_MANUAL, 8'd1);
               write_distance(CSR_DIST_CONNECTED, 8'd0);
               write_distance(CSR_DIST_RIP, 8'd120);
               write_distance(CSR_DIST_OSPF, 8'd110);
               write_distance(CSR_DIST_BGP, 8'd20);
            end
            default: ;
         endcase
         if (ph == 6) begin
            // Fill the table past its depth with distinct host routes.
            for (int k = 0; k < DEPTH + 4; k++) begin
               r = mk(ACT_ADD, 32'h0B000000 | k, 32'hFFFFFFFF, $urandom(), 4'($urandom()), 1,
                      16'($urandom()), SRC_MANUAL);
               send_route(r, 1'b0, ST_OK);
            end
            r = mk(ACT_ADD, 0, 0, 32'h77, 4'd7, 1, 16'd7, SRC_CONNECTED);
            send_route(r, 1'b0, ST_OK);
            for (int k = 0; k < DEPTH + 4; k++) begin
               r = mk(ACT_DELETE, 32'h0B000000 | k, 32'hFFFFFFFF, 0, 0, 0, 0, SRC_MANUAL);
               send_route(r, 1'b0, ST_OK);
            end
         end
         for (int n = 0; n < 250; n++) begin
            if (n == 125) while (pending_rsps.size() != 0) @(negedge clock);
            send_route(rand_route(), 1'b0, ST_OK);
         end
         drain_rsps();
      end

      if (errors == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end
endmodule
